// ===== hdl/lsrs_pkg.sv =====
// Shared types, register codes and helper functions for the link status
// register slave. No dependencies; every other file of the block but lsrs_ram uses it.

package lsrs_pkg;

    // Default size of the peer name store.
    localparam int NAME_BYTES_DEF = 32;

    // Item kinds.
    localparam logic [3:0] KIND_TICK    = 4'd0;
    localparam logic [3:0] KIND_CONN    = 4'd1;
    localparam logic [3:0] KIND_DISC    = 4'd2;
    localparam logic [3:0] KIND_START   = 4'd3;
    localparam logic [3:0] KIND_STOP    = 4'd4;
    localparam logic [3:0] KIND_VOLUME  = 4'd5;
    localparam logic [3:0] KIND_NAME    = 4'd6;
    localparam logic [3:0] KIND_WRITE   = 4'd7;
    localparam logic [3:0] KIND_READ    = 4'd8;

    // Link state codes.
    localparam logic [1:0] LINK_DISCONNECTED = 2'd1;
    localparam logic [1:0] LINK_CONNECTED    = 2'd2;
    localparam logic [1:0] LINK_PLAYING      = 2'd3;

    // Media action codes.
    localparam logic [2:0] MEDIA_NONE  = 3'd0;
    localparam logic [2:0] MEDIA_PLAY  = 3'd1;
    localparam logic [2:0] MEDIA_PAUSE = 3'd2;
    localparam logic [2:0] MEDIA_NEXT  = 3'd3;
    localparam logic [2:0] MEDIA_PREV  = 3'd4;

    // Media command data bytes.
    localparam logic [7:0] MCMD_PLAY_PAUSE = 8'd1;
    localparam logic [7:0] MCMD_NEXT       = 8'd2;
    localparam logic [7:0] MCMD_PREV       = 8'd3;

    // Bus register map.
    localparam logic [7:0] REG_STATE    = 8'h01;
    localparam logic [7:0] REG_SIGNAL   = 8'h02;
    localparam logic [7:0] REG_VOLUME   = 8'h03;
    localparam logic [7:0] REG_MEDIA    = 8'h0A;
    localparam logic [7:0] REG_NAME     = 8'h10;
    localparam logic [7:0] REG_VERSION  = 8'hF0;
    localparam logic [7:0] VERSION_BYTE = 8'd1;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  CFG_IDLE_TIMEOUT = 2'd0;
    localparam logic [1:0]  CFG_INT_PULSE    = 2'd1;
    localparam logic [1:0]  CFG_SIGNAL_LEVEL = 2'd2;
    localparam logic [23:0] IDLE_TIMEOUT_RST = 24'd300000;
    localparam logic [7:0]  INT_PULSE_RST    = 8'd5;
    localparam logic [7:0]  SIGNAL_LEVEL_RST = 8'd200;
    localparam logic [6:0]  VOLUME_RST       = 7'd50;

    typedef struct packed {
        logic [23:0] idle_timeout;
        logic [7:0]  int_pulse;
        logic [7:0]  signal_level;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;        // handle a single-result word now
        logic name_start;  // latch the start of a name read
        logic rd_issue;    // read the name store at the scan index
        logic step;        // consume the byte just read
        logic emit;        // load that byte into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic name_read;
        logic idx_ge_start;
        logic idx_last;
    } t_sts;

    // Maps 0..127 to floor(v * 100 / 127). Division by 2^7 - 1 is done as
    // (p + (p >> 7) + 1) >> 7, which is exact over the range of p here.
    function automatic logic [6:0] vol_scale(input logic [6:0] v);
        logic [13:0] p;
        logic [14:0] s;
        p = 14'({v, 6'd0}) + 14'({v, 5'd0}) + 14'({v, 2'd0});
        s = 15'(p) + 15'(p >> 7) + 15'd1;
        return s[13:7];
    endfunction

endpackage

// ===== hdl/link_status_register_slave.sv =====
// Top level of the link status register slave.
// Depends on lsrs_pkg, lsrs_apb, lsrs_ctrl and lsrs_dp.

// Status register bank of an audio link. Every input word except a name
// read is handled in the cycle it is accepted and yields one output word
// through the output register, so such words can be taken back to back
// while the output side keeps pace. A bus read with the register pointer in
// the name window scans the name store from its first byte through a RAM
// with registered read, one read state and one check state per byte, to
// find the end of the name; it returns one byte per word from the
// pointer's offset to the end of the store with last set on the final
// byte, and holds off new input until that final byte is in the output
// register. The name store needs no clearing pass: per-entry valid bits
// are cleared at reset and on a disconnect.

module link_status_register_slave #(
    parameter int NAME_BYTES = lsrs_pkg::NAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_kind,
    input  logic [6:0]  i_volume_in,
    input  logic [4:0]  i_name_index,
    input  logic [7:0]  i_name_char,
    input  logic [7:0]  i_bus_reg,
    input  logic [7:0]  i_bus_data,
    input  logic        i_bus_has_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_read_valid,
    output logic        o_last,
    output logic        o_int_level,
    output logic        o_disconnect_request,
    output logic [2:0]  o_media_action,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    lsrs_pkg::t_cfg cfg;
    lsrs_pkg::t_cmd cmd;
    lsrs_pkg::t_sts sts;

    lsrs_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lsrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lsrs_dp #(
        .NAME_BYTES (NAME_BYTES)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (cfg),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_kind               (i_kind),
        .i_volume_in          (i_volume_in),
        .i_name_index         (i_name_index),
        .i_name_char          (i_name_char),
        .i_bus_reg            (i_bus_reg),
        .i_bus_data           (i_bus_data),
        .i_bus_has_data       (i_bus_has_data),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_read_data          (o_read_data),
        .o_read_valid         (o_read_valid),
        .o_last               (o_last),
        .o_int_level          (o_int_level),
        .o_disconnect_request (o_disconnect_request),
        .o_media_action       (o_media_action)
    );
endmodule

// ===== hdl/lsrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.

module lsrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/lsrs_apb.sv =====
// Configuration register file on an APB-style port.
// Depends on lsrs_pkg for register indexes, reset values and t_cfg.

module lsrs_apb (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output lsrs_pkg::t_cfg       o_cfg
);
    lsrs_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout <= lsrs_pkg::IDLE_TIMEOUT_RST;
            r_cfg.int_pulse    <= lsrs_pkg::INT_PULSE_RST;
            r_cfg.signal_level <= lsrs_pkg::SIGNAL_LEVEL_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                lsrs_pkg::CFG_IDLE_TIMEOUT: r_cfg.idle_timeout <= pwdata[23:0];
                lsrs_pkg::CFG_INT_PULSE:    r_cfg.int_pulse    <= pwdata[7:0];
                lsrs_pkg::CFG_SIGNAL_LEVEL: r_cfg.signal_level <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lsrs_pkg::CFG_IDLE_TIMEOUT: prdata = {8'd0, r_cfg.idle_timeout};
            lsrs_pkg::CFG_INT_PULSE:    prdata = {24'd0, r_cfg.int_pulse};
            lsrs_pkg::CFG_SIGNAL_LEVEL: prdata = {24'd0, r_cfg.signal_level};
            default:                    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hdl/lsrs_ctrl.sv =====
// Controller for the link status register slave: accepts words and
// sequences the byte-by-byte scan of the name store on a name read.
// Depends on lsrs_pkg for t_cmd and t_sts.

module lsrs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lsrs_pkg::t_sts  i_sts,
    output lsrs_pkg::t_cmd  o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.name_read) begin
                        o_cmd.name_start = 1'b1;
                        n_state          = S_RD;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                // Bytes ahead of the start offset are scanned only to find
                // the end of the name; they are not returned.
                if (!i_sts.idx_ge_start) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.idx_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hdl/lsrs_dp.sv =====
// Datapath for the link status register slave: link state, timers, name
// store, the single-word event logic and the output register.
// Depends on lsrs_pkg and lsrs_ram.

module lsrs_dp #(
    parameter int NAME_BYTES = lsrs_pkg::NAME_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lsrs_pkg::t_cfg  i_cfg,
    input  lsrs_pkg::t_cmd  i_cmd,
    output lsrs_pkg::t_sts  o_sts,
    input  logic [3:0]      i_kind,
    input  logic [6:0]      i_volume_in,
    input  logic [4:0]      i_name_index,
    input  logic [7:0]      i_name_char,
    input  logic [7:0]      i_bus_reg,
    input  logic [7:0]      i_bus_data,
    input  logic            i_bus_has_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_read_data,
    output logic            o_read_valid,
    output logic            o_last,
    output logic            o_int_level,
    output logic            o_disconnect_request,
    output logic [2:0]      o_media_action
);
    localparam int AW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam logic [AW-1:0] IDX_LAST = AW'(NAME_BYTES - 1);
    localparam logic [8:0] NAME_END = 9'(int'(lsrs_pkg::REG_NAME) + NAME_BYTES);

    // Link state.
    logic [1:0]            r_link,  n_link;
    logic                  r_conn,  n_conn;
    logic                  r_play,  n_play;
    logic [6:0]            r_vol,   n_vol;
    logic [7:0]            r_ptr,   n_ptr;
    logic [23:0]           r_idle,  n_idle;
    logic                  r_pend,  n_pend;
    logic [7:0]            r_icnt,  n_icnt;
    logic [NAME_BYTES-1:0] r_name_vld, n_name_vld;

    // Name read scan.
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_start;
    logic                  r_seen_zero;
    logic                  r_rd_vld;

    // Output register.
    logic                  r_out_vld;
    logic [7:0]            r_out_data;
    logic                  r_out_rvld;
    logic                  r_out_last;
    logic                  r_out_int;
    logic                  r_out_disc;
    logic [2:0]            r_out_media;

    // Single-word result.
    logic [7:0]            ex_data;
    logic                  ex_rvld;
    logic                  ex_disc;
    logic [2:0]            ex_media;

    logic [23:0]           idle_inc;
    logic [7:0]            icnt_inc;
    logic                  name_wr_ok;
    logic                  ram_we;
    logic [7:0]            ram_rdata;
    logic [7:0]            raw_byte;
    logic [7:0]            name_byte;
    logic                  ptr_in_name;

    assign ptr_in_name = (r_ptr >= lsrs_pkg::REG_NAME) && ({1'b0, r_ptr} < NAME_END);
    assign name_wr_ok  = 32'(i_name_index) < 32'(NAME_BYTES);
    assign ram_we      = i_cmd.exec && (i_kind == lsrs_pkg::KIND_NAME) && name_wr_ok;

    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + 24'd1;
    assign icnt_inc = (r_icnt == '1) ? r_icnt : r_icnt + 8'd1;

    lsrs_ram #(
        .WIDTH (8),
        .DEPTH (NAME_BYTES)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_name_index)),
        .i_wdata (i_name_char),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // An entry never written since reset or the last disconnect reads zero.
    assign raw_byte  = r_rd_vld ? ram_rdata : 8'd0;
    assign name_byte = r_seen_zero ? 8'd0 : raw_byte;

    assign o_sts.out_free     = !r_out_vld || i_out_ready;
    assign o_sts.name_read    = (i_kind == lsrs_pkg::KIND_READ) && ptr_in_name;
    assign o_sts.idx_ge_start = r_idx >= r_start;
    assign o_sts.idx_last     = r_idx == IDX_LAST;

    always_comb begin
        n_link     = r_link;
        n_conn     = r_conn;
        n_play     = r_play;
        n_vol      = r_vol;
        n_ptr      = r_ptr;
        n_idle     = r_idle;
        n_pend     = r_pend;
        n_icnt     = r_icnt;
        n_name_vld = r_name_vld;
        ex_data    = 8'd0;
        ex_rvld    = 1'b0;
        ex_disc    = 1'b0;
        ex_media   = lsrs_pkg::MEDIA_NONE;
        if (i_cmd.exec) begin
            case (i_kind)
                lsrs_pkg::KIND_TICK: begin
                    if (r_conn && !r_play) begin
                        if (idle_inc > i_cfg.idle_timeout) begin
                            ex_disc = 1'b1;
                            n_idle  = 24'd0;
                        end else begin
                            n_idle = idle_inc;
                        end
                    end else begin
                        n_idle = 24'd0;
                    end
                    if (r_pend) begin
                        n_icnt = icnt_inc;
                        if (icnt_inc >= i_cfg.int_pulse) begin
                            n_pend = 1'b0;
                        end
                    end
                end
                lsrs_pkg::KIND_CONN: begin
                    n_conn = 1'b1;
                    n_link = lsrs_pkg::LINK_CONNECTED;
                    n_idle = 24'd0;
                    n_pend = 1'b1;
                    n_icnt = 8'd0;
                end
                lsrs_pkg::KIND_DISC: begin
                    n_conn     = 1'b0;
                    n_link     = lsrs_pkg::LINK_DISCONNECTED;
                    n_name_vld = '0;
                    n_idle     = 24'd0;
                    n_pend     = 1'b1;
                    n_icnt     = 8'd0;
                end
                lsrs_pkg::KIND_START: begin
                    n_play = 1'b1;
                    n_link = lsrs_pkg::LINK_PLAYING;
                    n_pend = 1'b1;
                    n_icnt = 8'd0;
                end
                lsrs_pkg::KIND_STOP: begin
                    n_play = 1'b0;
                    n_link = lsrs_pkg::LINK_CONNECTED;
                    n_idle = 24'd0;
                    n_pend = 1'b1;
                    n_icnt = 8'd0;
                end
                lsrs_pkg::KIND_VOLUME: begin
                    n_vol  = lsrs_pkg::vol_scale(i_volume_in);
                    n_pend = 1'b1;
                    n_icnt = 8'd0;
                end
                lsrs_pkg::KIND_NAME: begin
                    if (name_wr_ok) begin
                        n_name_vld[AW'(i_name_index)] = 1'b1;
                    end
                end
                lsrs_pkg::KIND_WRITE: begin
                    n_ptr = i_bus_reg;
                    if (i_bus_has_data && (i_bus_reg == lsrs_pkg::REG_MEDIA)) begin
                        case (i_bus_data)
                            lsrs_pkg::MCMD_PLAY_PAUSE:
                                ex_media = r_play ? lsrs_pkg::MEDIA_PAUSE
                                                  : lsrs_pkg::MEDIA_PLAY;
                            lsrs_pkg::MCMD_NEXT: ex_media = lsrs_pkg::MEDIA_NEXT;
                            lsrs_pkg::MCMD_PREV: ex_media = lsrs_pkg::MEDIA_PREV;
                            default:             ex_media = lsrs_pkg::MEDIA_NONE;
                        endcase
                    end
                end
                lsrs_pkg::KIND_READ: begin
                    ex_rvld = 1'b1;
                    case (r_ptr)
                        lsrs_pkg::REG_STATE:   ex_data = {6'd0, r_link};
                        lsrs_pkg::REG_SIGNAL:  ex_data = r_conn ? i_cfg.signal_level : 8'd0;
                        lsrs_pkg::REG_VOLUME:  ex_data = {1'b0, r_vol};
                        lsrs_pkg::REG_VERSION: ex_data = lsrs_pkg::VERSION_BYTE;
                        default:               ex_data = 8'd0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link     <= lsrs_pkg::LINK_DISCONNECTED;
            r_conn     <= 1'b0;
            r_play     <= 1'b0;
            r_vol      <= lsrs_pkg::VOLUME_RST;
            r_ptr      <= 8'd0;
            r_idle     <= 24'd0;
            r_pend     <= 1'b0;
            r_icnt     <= 8'd0;
            r_name_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_link     <= n_link;
            r_conn     <= n_conn;
            r_play     <= n_play;
            r_vol      <= n_vol;
            r_ptr      <= n_ptr;
            r_idle     <= n_idle;
            r_pend     <= n_pend;
            r_icnt     <= n_icnt;
            r_name_vld <= n_name_vld;
            if (i_cmd.exec || i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.name_start) begin
            r_idx       <= '0;
            r_start     <= AW'(r_ptr - lsrs_pkg::REG_NAME);
            r_seen_zero <= 1'b0;
        end else if (i_cmd.step) begin
            r_seen_zero <= r_seen_zero || (raw_byte == 8'd0);
            if (!o_sts.idx_last) begin
                r_idx <= r_idx + AW'(1);
            end
        end
        if (i_cmd.rd_issue) begin
            r_rd_vld <= r_name_vld[r_idx];
        end
        if (i_cmd.exec) begin
            r_out_data  <= ex_data;
            r_out_rvld  <= ex_rvld;
            r_out_last  <= 1'b1;
            r_out_int   <= n_pend;
            r_out_disc  <= ex_disc;
            r_out_media <= ex_media;
        end else if (i_cmd.emit) begin
            r_out_data  <= name_byte;
            r_out_rvld  <= 1'b1;
            r_out_last  <= o_sts.idx_last;
            r_out_int   <= r_pend;
            r_out_disc  <= 1'b0;
            r_out_media <= lsrs_pkg::MEDIA_NONE;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_read_data          = r_out_data;
    assign o_read_valid         = r_out_rvld;
    assign o_last               = r_out_last;
    assign o_int_level          = r_out_int;
    assign o_disconnect_request = r_out_disc;
    assign o_media_action       = r_out_media;
endmodule

// ===== hdl/lsrs_chk.sv =====
// Port-level checker for the link status register slave, with its bind.
// Depends on lsrs_pkg for the media action codes.

module lsrs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_read_data,
    input logic        o_read_valid,
    input logic        o_last,
    input logic        o_disconnect_request,
    input logic [2:0]  o_media_action
);
    // A returned byte never carries a link request or a media action.
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |->
            o_media_action == lsrs_pkg::MEDIA_NONE && !o_disconnect_request)
        else $error("read word carries an action");

    // A word that is not a read is a single result with an empty data byte.
    a_event_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> o_last && o_read_data == 8'd0)
        else $error("event word is not a single empty result");

    // While a name read still has bytes to return, no new word is taken.
    a_name_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid && !o_last |-> !o_in_ready)
        else $error("input taken in the middle of a name read");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_read_data) && $stable(o_last))
        else $error("stalled output word changed");
endmodule

bind link_status_register_slave lsrs_chk u_lsrs_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_in_ready           (o_in_ready),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_read_data          (o_read_data),
    .o_read_valid         (o_read_valid),
    .o_last               (o_last),
    .o_disconnect_request (o_disconnect_request),
    .o_media_action       (o_media_action)
);
